FILE: hdl/amsa_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the audio memory stream accelerator.
// No dependencies; imported by the top level.
package amsa_pkg;

    localparam int unsigned ADDR_BITS = 32;
    localparam int unsigned END_BITS  = 27;
    localparam int unsigned FMT_BITS  = 5;
    localparam int unsigned DATA_BITS = 16;
    localparam int unsigned IN_TDATA_BITS  = 56;
    localparam int unsigned OUT_TDATA_BITS = 64;

    typedef enum logic [1:0] {
        MODE_READ  = 2'd0,
        MODE_WRITE = 2'd1,
        MODE_LOAD  = 2'd2,
        MODE_CLEAR = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        CFG_FORMAT = 2'd0,
        CFG_START  = 2'd1,
        CFG_END    = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0] {
        SIZE_NIBBLE  = 2'd0,
        SIZE_BYTE    = 2'd1,
        SIZE_WORD    = 2'd2,
        SIZE_INVALID = 2'd3
    } size_t;

    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_FORMAT    = 2'd1,
        ERR_DIRECTION = 2'd2
    } error_t;

    typedef enum logic [1:0] {
        VEC_DECODED = 2'd0,
        VEC_RAW     = 2'd1,
        VEC_WRITE   = 2'd2
    } vector_t;

    typedef enum logic [1:0] {
        KIND_NONE   = 2'd0,
        KIND_NIBBLE = 2'd1,
        KIND_BYTE   = 2'd2,
        KIND_WORD   = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic        refresh;
        logic        bank_sel;
        logic        nib_low;
        logic [31:0] cur_addr;
        logic        wrapped;
        logic        pending;
        logic [1:0]  vector;
        error_t      error;
    } result_t;

endpackage

FILE: hdl/amsa_ram.sv
`timescale 1ns / 1ps
// Generic single-port synchronous RAM with a registered read.
// No dependencies.
module amsa_ram #(
    parameter int WIDTH = 8,
    parameter int ADDR_BITS = 15
) (
    input  logic                 clk,
    input  logic                 en,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] addr,
    input  logic [WIDTH-1:0]     wdata,
    output logic [WIDTH-1:0]     rdata
);

    logic [WIDTH-1:0] mem [0:(1 << ADDR_BITS)-1];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/audio_memory_stream_accelerator.sv
`timescale 1ns / 1ps
// Top level of the audio memory stream accelerator: address engine and result stage.
// Depends on amsa_pkg and amsa_ram (two byte banks, even and odd addresses).
//
// Channel  Direction  Handshake          Content
// s_*      in         s_tvalid/s_tready  item: mode in tuser, data and address in tdata
// m_*      out        m_tvalid/m_tready  result item: data, address, flags in tdata
// cfg_*    in         cfg_valid/cfg_ready register index and value, always ready
//
// One item per cycle is taken unless output stalls; its result appears next cycle.
// The address update never waits for read data, so the two memory
// banks are read or written in the accept cycle and their registered outputs
// feed the result. A stalled result holds the bank outputs and blocks intake.
// Reset clears the address, overflow state and registers; memory is not cleared.
module audio_memory_stream_accelerator #(
    parameter int MEM_ADDR_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // write_data[15:0], load_address[47:16], irq_enable[48], zero fill
    input  logic [55:0] s_tdata,
    // mode[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // read_data[15:0], pred_scale[23:16], current_address[55:24], wrapped[56],
    // overflow_pending[57], overflow_vector[59:58], error[61:60], zero fill
    output logic [63:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import amsa_pkg::*;

    localparam int BANK_BITS = MEM_ADDR_BITS - 1;

    logic [4:0]  format_reg;
    logic [31:0] start_reg;
    logic [26:0] end_reg;
    logic [31:0] cur_reg;
    logic [31:0] cur_next;
    logic        pend_reg;
    logic        pend_next;
    logic [1:0]  vec_reg;
    logic [1:0]  vec_next;
    logic [7:0]  pred_reg;
    logic        s1_valid_reg;
    result_t     s1_reg;
    result_t     s1_next;

    mode_t       mode;
    logic [15:0] write_data;
    logic [31:0] load_address;
    logic        irq_enable;
    logic        accept;
    logic        read_ok;
    logic        refresh;
    logic [31:0] addr_a;
    logic [31:0] addr_inc;
    logic        wrap;
    logic [27:0] byte_idx;
    logic [BANK_BITS-1:0] bank_addr;
    logic        bank0_en;
    logic        bank1_en;
    logic        bank_we;
    logic [7:0]  bank0_rdata;
    logic [7:0]  bank1_rdata;
    logic [7:0]  data_byte;
    logic [15:0] read_data;
    logic [7:0]  pred_out;

    assign mode         = mode_t'(s_tuser);
    assign write_data   = s_tdata[15:0];
    assign load_address = s_tdata[47:16];
    assign irq_enable   = s_tdata[48];

    assign cfg_ready = 1'b1;
    assign s_tready  = !s1_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            format_reg <= '0;
            start_reg  <= '0;
            end_reg    <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_FORMAT: format_reg <= cfg_data[4:0];
                CFG_START:  start_reg  <= cfg_data;
                CFG_END:    end_reg    <= cfg_data[26:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        read_ok  = 1'b0;
        refresh  = 1'b0;
        addr_a   = cur_reg;
        byte_idx = {cur_reg[26:0], 1'b0};
        bank0_en = 1'b0;
        bank1_en = 1'b0;
        bank_we  = 1'b0;
        cur_next = cur_reg;
        pend_next = pend_reg;
        vec_next = vec_reg;
        s1_next = '0;
        s1_next.kind = KIND_NONE;
        s1_next.error = ERR_NONE;

        case (mode)
            MODE_READ:
            begin
                if (cur_reg[31])
                begin
                    s1_next.error = ERR_DIRECTION;
                end
                else if (format_reg[1:0] == SIZE_INVALID)
                begin
                    s1_next.error = ERR_FORMAT;
                end
                else
                begin
                    read_ok = 1'b1;
                end
            end
            MODE_WRITE:
            begin
                if (!cur_reg[31])
                begin
                    s1_next.error = ERR_DIRECTION;
                end
                else
                begin
                    bank_we  = 1'b1;
                    bank0_en = 1'b1;
                    bank1_en = 1'b1;
                end
            end
            MODE_LOAD:
            begin
                cur_next = load_address;
            end
            default:
            begin
                pend_next = 1'b0;
            end
        endcase

        if (read_ok)
        begin
            case (format_reg[1:0])
                SIZE_NIBBLE:
                begin
                    refresh = (cur_reg[3:0] == 4'h0) && (format_reg[3:2] == 2'd0);
                    addr_a  = refresh ? cur_reg + 32'd2 : cur_reg;
                    byte_idx = {2'b00, addr_a[26:1]};
                    s1_next.kind = KIND_NIBBLE;
                end
                SIZE_BYTE:
                begin
                    byte_idx = {1'b0, cur_reg[26:0]};
                    s1_next.kind = KIND_BYTE;
                end
                default:
                begin
                    s1_next.kind = KIND_WORD;
                end
            endcase
            if (refresh || s1_next.kind == KIND_WORD)
            begin
                bank0_en = 1'b1;
                bank1_en = 1'b1;
            end
            else
            begin
                bank0_en = !byte_idx[0];
                bank1_en = byte_idx[0];
            end
        end

        addr_inc = addr_a + 32'd1;
        wrap = (addr_inc[26:0] >= end_reg);
        if (read_ok || bank_we)
        begin
            cur_next = addr_inc;
            if (wrap)
            begin
                cur_next = start_reg | {bank_we, 31'd0};
                if (irq_enable)
                begin
                    pend_next = 1'b1;
                    if (bank_we)
                    begin
                        vec_next = VEC_WRITE;
                    end
                    else
                    begin
                        vec_next = (format_reg[4:3] == 2'd0) ? VEC_DECODED : VEC_RAW;
                    end
                end
            end
        end

        s1_next.refresh  = refresh;
        s1_next.bank_sel = byte_idx[0];
        s1_next.nib_low  = addr_a[0];
        s1_next.cur_addr = cur_next;
        s1_next.wrapped  = (read_ok || bank_we) && wrap;
        s1_next.pending  = pend_next;
        s1_next.vector   = vec_next;
    end

    assign bank_addr = byte_idx[MEM_ADDR_BITS-1:1];

    amsa_ram #(
        .WIDTH(8),
        .ADDR_BITS(BANK_BITS)
    ) u_bank_even (
        .clk(clk),
        .en(accept && bank0_en),
        .we(bank_we),
        .addr(bank_addr),
        .wdata(write_data[15:8]),
        .rdata(bank0_rdata)
    );

    amsa_ram #(
        .WIDTH(8),
        .ADDR_BITS(BANK_BITS)
    ) u_bank_odd (
        .clk(clk),
        .en(accept && bank1_en),
        .we(bank_we),
        .addr(bank_addr),
        .wdata(write_data[7:0]),
        .rdata(bank1_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg      <= '0;
            pend_reg     <= 1'b0;
            vec_reg      <= '0;
            pred_reg     <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_valid_reg && s1_reg.refresh)
            begin
                pred_reg <= bank0_rdata;
            end
            if (accept)
            begin
                cur_reg      <= cur_next;
                pend_reg     <= pend_next;
                vec_reg      <= vec_next;
                s1_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg <= s1_next;
        end
    end

    always_comb
    begin
        data_byte = (s1_reg.refresh || s1_reg.bank_sel) ? bank1_rdata : bank0_rdata;
        case (s1_reg.kind)
            KIND_NIBBLE: read_data = {12'd0, s1_reg.nib_low ? data_byte[3:0] : data_byte[7:4]};
            KIND_BYTE:   read_data = {8'd0, data_byte};
            KIND_WORD:   read_data = {bank0_rdata, bank1_rdata};
            default:     read_data = '0;
        endcase
    end

    assign pred_out = (s1_valid_reg && s1_reg.refresh) ? bank0_rdata : pred_reg;

    assign m_tvalid = s1_valid_reg;
    assign m_tdata  = {2'b00, s1_reg.error, s1_reg.vector, s1_reg.pending, s1_reg.wrapped,
                       s1_reg.cur_addr, pred_out, read_data};

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the audio memory stream accelerator.
// Depends on amsa_pkg and the RTL of the top level. It fills the sample memory first,
// then runs directed and random item streams against an in-bench predictor.
module testbench;
    import amsa_pkg::*;

    localparam int MEM_BITS = 16;
    localparam int RANDOM_SETTINGS = 24;
    localparam int unsigned CYCLE_LIMIT = 1_000_000;

    typedef struct packed {
        logic [15:0] read_data;
        logic [7:0]  pred_scale;
        logic [31:0] address;
        logic        wrapped;
        logic        pending;
        logic [1:0]  vector;
        logic [1:0]  error;
    } access_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    logic [4:0]  model_fmt = '0;
    logic [31:0] model_start = '0;
    logic [26:0] model_end = '0;
    logic [31:0] model_addr = '0;
    logic [7:0]  model_scale = '0;
    logic        model_pending = 1'b0;
    logic [1:0]  model_vector = VEC_DECODED;
    logic [7:0]  sample_mem [0:(1 << MEM_BITS) - 1];

    access_result_t predicted_results[$];
    access_result_t want;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_left = 0;
    int errors = 0;
    int items_sent = 0;
    int results_seen = 0;
    int wrap_count = 0;
    int refused_count = 0;
    int settings_used = 0;
    int unsigned cycle_count = 0;

    audio_memory_stream_accelerator #(.MEM_ADDR_BITS(MEM_BITS)) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $error("Run stopped after %0d cycles without finishing.", CYCLE_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // A long hold-off takes precedence over the random stalls.
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            m_tready <= 1'b0;
            hold_left = hold_left - 1;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic logic [7:0] mem_byte(input logic [27:0] a);
        return sample_mem[a[MEM_BITS-1:0]];
    endfunction

    task automatic step_address(input logic is_write, input logic irq, output logic wrapped);
        model_addr = model_addr + 32'd1;
        wrapped = (model_addr[26:0] >= model_end);
        if (wrapped)
        begin
            model_addr = model_start;
            if (is_write)
                model_addr[31] = 1'b1;
            if (irq)
            begin
                model_pending = 1'b1;
                if (is_write)
                    model_vector = VEC_WRITE;
                else if (model_fmt[4:3] == 2'b00)
                    model_vector = VEC_DECODED;
                else
                    model_vector = VEC_RAW;
            end
        end
    endtask

    task automatic predict_access(input mode_t m, input logic [15:0] wdata,
                                  input logic [31:0] laddr, input logic irq);
        access_result_t r;
        logic [7:0]     b;
        logic [27:0]    wa;
        logic [27:0]    wa_next;
        r = '0;
        case (m)
            MODE_READ:
                if (model_addr[31])
                    r.error = ERR_DIRECTION;
                else if (model_fmt[1:0] == SIZE_INVALID)
                    r.error = ERR_FORMAT;
                else
                begin
                    case (model_fmt[1:0])
                        SIZE_NIBBLE:
                        begin
                            // The scale reloads at each 16-nibble boundary if fmt[3:2] is 0.
                            if (model_addr[3:0] == 4'h0 && model_fmt[3:2] == 2'b00)
                            begin
                                model_scale = mem_byte(model_addr[26:1]);
                                model_addr = model_addr + 32'd2;
                            end
                            b = mem_byte(model_addr[26:1]);
                            r.read_data = model_addr[0] ? {12'h0, b[3:0]} : {12'h0, b[7:4]};
                        end
                        SIZE_BYTE:
                            r.read_data = {8'h0, mem_byte(model_addr[26:0])};
                        default:
                        begin
                            wa = {model_addr[26:0], 1'b0};
                            r.read_data = {mem_byte(wa), mem_byte(wa + 28'd1)};
                        end
                    endcase
                    step_address(1'b0, irq, r.wrapped);
                end
            MODE_WRITE:
                if (!model_addr[31])
                    r.error = ERR_DIRECTION;
                else
                begin
                    wa = {model_addr[26:0], 1'b0};
                    wa_next = wa + 28'd1;
                    sample_mem[wa[MEM_BITS-1:0]] = wdata[15:8];
                    sample_mem[wa_next[MEM_BITS-1:0]] = wdata[7:0];
                    step_address(1'b1, irq, r.wrapped);
                end
            MODE_LOAD:
                model_addr = laddr;
            default:
                model_pending = 1'b0;
        endcase
        r.pred_scale = model_scale;
        r.address = model_addr;
        r.pending = model_pending;
        r.vector = model_vector;
        predicted_results.push_back(r);
    endtask

    task automatic check_field(input string name, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (want_v !== got_v)
        begin
            $error("%s mismatch: expected %h, got %h", name, want_v, got_v);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (predicted_results.size() == 0)
            begin
                $error("Result item with nothing expected: tdata %h", m_tdata);
                errors++;
            end
            else
            begin
                want = predicted_results.pop_front();
                results_seen++;
                if (want.wrapped)
                    wrap_count++;
                if (want.error != ERR_NONE)
                    refused_count++;
                check_field("read_data", want.read_data, m_tdata[15:0]);
                check_field("pred_scale", want.pred_scale, m_tdata[23:16]);
                check_field("current_address", want.address, m_tdata[55:24]);
                check_field("wrapped", want.wrapped, m_tdata[56]);
                check_field("overflow_pending", want.pending, m_tdata[57]);
                check_field("overflow_vector", want.vector, m_tdata[59:58]);
                check_field("error", want.error, m_tdata[61:60]);
            end
        end
    end

    // Called at a falling edge; returns at a falling edge with the item valid line still high.
    task automatic send_item(input mode_t m, input logic [15:0] wdata,
                             input logic [31:0] laddr, input logic irq);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= m;
        s_tdata <= {7'b0, irq, laddr, wdata};
        do @(posedge clk); while (!s_tready);
        predict_access(m, wdata, laddr, irq);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic wait_drain();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (predicted_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_register(input cfg_index_t idx, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_FORMAT: model_fmt = value[4:0];
            CFG_START:  model_start = value;
            default:    model_end = value[26:0];
        endcase
        @(negedge clk);
    endtask

    task automatic configure(input logic [4:0] fmt, input logic [31:0] start_a,
                             input logic [26:0] end_a);
        wait_drain();
        write_register(CFG_FORMAT, {27'b0, fmt});
        write_register(CFG_START, start_a);
        write_register(CFG_END, {5'b0, end_a});
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // The lowest 512 and the highest 256 bytes are written here, and every later read
    // stays inside these two windows.
    task automatic test_memory_fill();
        configure({3'b000, SIZE_BYTE}, 32'h8000_0000, 27'h8000);
        send_item(MODE_LOAD, 16'h0000, 32'h8000_0000, 1'b0);
        repeat (256)
            send_item(MODE_WRITE, 16'($urandom()), $urandom(), 1'b0);
        send_item(MODE_LOAD, 16'h0000, 32'h8000_7F80, 1'b0);
        repeat (128)
            send_item(MODE_WRITE, 16'($urandom()), $urandom(), 1'b0);
    endtask

    task automatic test_directed();
        // Nibble stream: no refresh off the boundary, then a refresh followed by a wrap.
        configure(5'h00, 32'h0000_0000, 27'h11);
        send_item(MODE_LOAD, 16'h0000, 32'h0000_000F, 1'b1);
        send_item(MODE_READ, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
        send_item(MODE_READ, 16'h0000, 32'h0000_0000, 1'b1);
        send_item(MODE_READ, 16'h0000, 32'h0000_0000, 1'b0);
        send_item(MODE_READ, 16'h0000, 32'h0000_0000, 1'b0);
        send_item(MODE_CLEAR, 16'h0000, 32'h0000_0000, 1'b0);
        // Accesses against the direction bit are refused.
        send_item(MODE_WRITE, 16'hA5A5, 32'h0000_0000, 1'b1);
        send_item(MODE_LOAD, 16'h0000, 32'h8000_0010, 1'b0);
        send_item(MODE_READ, 16'h0000, 32'h0000_0000, 1'b1);
        // Word writes across the top of the address space and wraps with and without enable.
        configure({3'b000, SIZE_WORD}, 32'h0000_0123, 27'h5);
        send_item(MODE_LOAD, 16'h0000, 32'hFFFF_FFFF, 1'b0);
        send_item(MODE_WRITE, 16'hFFFF, 32'h0000_0000, 1'b0);
        send_item(MODE_WRITE, 16'h0000, 32'h0000_0000, 1'b1);
        send_item(MODE_LOAD, 16'h0000, 32'h8000_0004, 1'b0);
        send_item(MODE_WRITE, 16'h1234, 32'h0000_0000, 1'b0);
        send_item(MODE_LOAD, 16'h0000, 32'h8000_0004, 1'b0);
        send_item(MODE_WRITE, 16'hFEDC, 32'h0000_0000, 1'b1);
        send_item(MODE_READ, 16'h0000, 32'h0000_0000, 1'b0);
        send_item(MODE_LOAD, 16'h0000, 32'h0000_0004, 1'b0);
        send_item(MODE_READ, 16'h0000, 32'h0000_0000, 1'b1);
        // Byte reads at the highest end address with a nonzero vector select.
        configure(5'h19, 32'h7FFF_FFFF, 27'h7FF_FFFF);
        send_item(MODE_LOAD, 16'h0000, 32'h07FF_FFFE, 1'b0);
        send_item(MODE_READ, 16'h0000, 32'h0000_0000, 1'b1);
        send_item(MODE_READ, 16'h0000, 32'h0000_0000, 1'b0);
        send_item(MODE_READ, 16'h0000, 32'h0000_0000, 1'b0);
        send_item(MODE_CLEAR, 16'h0000, 32'h0000_0000, 1'b1);
        // Gated refresh with a raw-read vector on wrap.
        configure(5'h0C, 32'h0000_0000, 27'h21);
        send_item(MODE_LOAD, 16'h0000, 32'h0000_0020, 1'b0);
        send_item(MODE_READ, 16'h0000, 32'h0000_0000, 1'b1);
        // Invalid size, and an end address of zero where every access wraps.
        configure(5'h1F, 32'h0000_0000, 27'h0);
        send_item(MODE_READ, 16'h0000, 32'h0000_0000, 1'b1);
        send_item(MODE_LOAD, 16'h0000, 32'h8000_0000, 1'b0);
        send_item(MODE_WRITE, 16'h5A5A, 32'h0000_0000, 1'b1);
    endtask

    // The receiver holds off while the sender keeps offering, so intake must stall.
    task automatic test_backpressure();
        configure({3'b000, SIZE_BYTE}, 32'h0000_0000, 27'h40);
        send_item(MODE_LOAD, 16'h0000, 32'h0000_0000, 1'b0);
        hold_left = 300;
        repeat (60)
            send_item(MODE_READ, 16'($urandom()), $urandom(), 1'($urandom_range(1)));
    endtask

    task automatic test_random_stream(input int setting);
        logic [4:0]  fmt;
        logic [26:0] end_a;
        logic [26:0] start_lo;
        logic [31:0] start_a;
        logic [31:0] entry;
        logic [31:0] laddr;
        logic        to_write;
        mode_t       m;
        int          span;
        int          roll;
        fmt = 5'($urandom_range(31));
        if (fmt[1:0] == SIZE_INVALID && $urandom_range(3) != 0)
            fmt[1:0] = SIZE_BYTE;
        span = $urandom_range(1, 80);
        // The low address bits stay small so that every access lands in the filled bytes.
        start_lo = {10'($urandom_range(1023)), 17'($urandom_range(31))};
        end_a = start_lo + 27'(span);
        if (setting == 0)
        begin
            fmt = 5'h00;
            end_a = 27'h7FF_FFFF;
            start_lo = end_a - 27'(span);
        end
        if (setting == 1)
        begin
            fmt = 5'h1F;
            end_a = 27'h0;
            start_lo = 27'h0;
        end
        to_write = 1'($urandom_range(1));
        start_a = {($urandom_range(4) == 0), 4'($urandom_range(15)), start_lo};
        if (setting == 2)
            start_a = 32'hFFFF_FFFF;
        entry = {to_write, 4'($urandom_range(15)), start_lo};
        configure(fmt, start_a, end_a);
        send_item(MODE_LOAD, 16'($urandom()), entry, 1'($urandom_range(1)));
        repeat ($urandom_range(20, 40))
        begin
            roll = $urandom_range(99);
            if (roll < 80)
                m = to_write ? MODE_WRITE : MODE_READ;
            else if (roll < 86)
                m = to_write ? MODE_READ : MODE_WRITE;
            else if (roll < 91)
                m = MODE_CLEAR;
            else
                m = MODE_LOAD;
            laddr = $urandom();
            if (m == MODE_LOAD)
            begin
                if (roll < 97)
                    laddr = entry;
                else
                begin
                    laddr = entry + 32'($urandom_range(15));
                    laddr[31:27] = 5'($urandom_range(31));
                end
            end
            send_item(m, 16'($urandom()), laddr, 1'($urandom_range(1)));
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        send_idle_pct = 14;
        recv_idle_pct = 60;
        test_memory_fill();
        test_directed();
        test_backpressure();
        for (int k = 0; k < RANDOM_SETTINGS; k++)
        begin
            if (k == RANDOM_SETTINGS / 3)
            begin
                send_idle_pct = 60;
                recv_idle_pct = 14;
            end
            if (k == 2 * RANDOM_SETTINGS / 3)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            test_random_stream(k);
        end
        wait_drain();
        repeat (4) @(posedge clk);
        $display("Run covered %0d items over %0d register settings, memory fill included.",
                 items_sent, settings_used);
        $display("Checked %0d results with %0d wraps and %0d refused accesses.",
                 results_seen, wrap_count, refused_count);
        if (errors == 0 && predicted_results.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: audio_memory_stream_accelerator.f
hdl/amsa_pkg.sv
hdl/amsa_ram.sv
hdl/audio_memory_stream_accelerator.sv
tb/sv/testbench.sv
